// File: sv/bbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bbt_pkg;

    // Map geometry.
    localparam int BLOCK_COUNT    = 1024;
    localparam int CHIP_COUNT     = 2;
    localparam int WORD_W         = 16;
    localparam int WORDS_PER_CHIP = BLOCK_COUNT / WORD_W;
    localparam int MAP_DEPTH      = CHIP_COUNT * WORDS_PER_CHIP;

    // Field and address widths.
    localparam int OP_W    = 2;
    localparam int CHIP_W  = 1;
    localparam int BLOCK_W = 10;
    localparam int BIT_W   = $clog2(WORD_W);
    localparam int WPC_W   = $clog2(WORDS_PER_CHIP);
    localparam int ADDR_W  = CHIP_W + WPC_W;

    // Request codes.
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_MARK  = 2'd1;
    localparam logic [OP_W-1:0] OP_TEST  = 2'd2;
    localparam logic [OP_W-1:0] OP_FIND  = 2'd3;

    typedef struct packed {
        logic               is_bad;
        logic [BLOCK_W-1:0] next_good;
        logic               found;
    } result_t;

    // Index of the lowest set bit; zero when no bit is set.
    function automatic logic [BIT_W-1:0] lowest_one(input logic [WORD_W-1:0] word);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (word[i])
            begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// File: sv/bbt_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bbt_req_if;
    import bbt_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [CHIP_W-1:0]  chip;
    logic [BLOCK_W-1:0] block;
    logic               bad_in;

    modport source (output valid, op, chip, block, bad_in, input ready);
    modport sink (input valid, op, chip, block, bad_in, output ready);
endinterface

interface bbt_rsp_if;
    import bbt_pkg::*;

    logic               valid;
    logic               ready;
    logic               is_bad;
    logic [BLOCK_W-1:0] next_good;
    logic               found;

    modport source (output valid, is_bad, next_good, found, input ready);
    modport sink (input valid, is_bad, next_good, found, output ready);
endinterface

`default_nettype wire

// File: sv/bad_block_bitmap_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Bad-block map for two flash chips, one bit per block, kept in a 128 x 16-bit
// synchronous RAM with a valid bit per row so that reset and clear take effect at
// once. Every request gives exactly one result item. Clear, a mark with bad_in low
// and a find-next from the last block finish in the cycle they are accepted; mark
// (read-modify-write) and test finish in S_ACCESS. Find-next otherwise reads one
// 16-bit map word per cycle from the block after the given one to the end of the
// chip. The next request is taken as soon as the previous one has finished, while
// its result still waits in the output register; if that register is still full
// when a request finishes, no request is taken until the result moves into it.
module bad_block_bitmap_table (
    input  wire logic clk,
    input  wire logic rst_n,
    bbt_req_if.sink   req,
    bbt_rsp_if.source rsp
);
    import bbt_pkg::*;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    bbt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    bbt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAP_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

`ifndef SYNTH
    // A map write comes only from an accepted clear or from the mark update cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (!req.ready || (req.valid && req.op == OP_CLEAR)))
        else $error("map written outside a clear or mark update");

    // A test needs the map word, so the request port must close after it is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.op == OP_TEST) |=> !req.ready)
        else $error("test request finished without reading the map");

    // The search starts above the start block, so block 0 is never returned.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.found) |-> (rsp.next_good != '0 && !rsp.is_bad))
        else $error("find result reports block 0 or a bad flag");
`endif

endmodule

`default_nettype wire

// File: sv/bbt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bbt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: sv/bbt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bbt_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    bbt_req_if.sink                         req,
    bbt_rsp_if.source                       rsp,
    output logic                            ram_we,
    output logic      [bbt_pkg::ADDR_W-1:0] ram_waddr,
    output logic      [bbt_pkg::WORD_W-1:0] ram_wdata,
    output logic      [bbt_pkg::ADDR_W-1:0] ram_raddr,
    input  wire logic [bbt_pkg::WORD_W-1:0] ram_rdata
);
    import bbt_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_ACCESS = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_HOLD   = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [CHIP_W-1:0]    chip_reg, chip_next;
    logic [WPC_W-1:0]     word_reg, word_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [WORD_W-1:0]    mask_reg, mask_next;
    result_t              pend_reg, pend_next;
    result_t              out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 rd_valid_reg;
    logic [MAP_DEPTH-1:0] row_valid_reg, row_valid_next;

    logic [WORD_W-1:0]    word_data;
    logic [WORD_W-1:0]    good;
    logic [BLOCK_W-1:0]   start;
    logic                 fin;
    logic                 can_emit;
    result_t              res;

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.is_bad    = out_reg.is_bad;
    assign rsp.next_good = out_reg.next_good;
    assign rsp.found     = out_reg.found;

    // A row that has not been written since its chip was cleared reads as all good.
    assign word_data = rd_valid_reg ? ram_rdata : '0;
    assign good      = ~word_data & mask_reg;
    assign start     = req.block + BLOCK_W'(1);
    assign can_emit  = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next     = state_reg;
        chip_next      = chip_reg;
        word_next      = word_reg;
        bit_next       = bit_reg;
        op_next        = op_reg;
        mask_next      = mask_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        row_valid_next = row_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = {req.chip, req.block[BLOCK_W-1:BIT_W]};
        fin            = 1'b0;
        res            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    chip_next = req.chip;
                    word_next = req.block[BLOCK_W-1:BIT_W];
                    bit_next  = req.block[BIT_W-1:0];
                    op_next   = req.op;
                    if (int'(req.chip) >= CHIP_COUNT)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        case (req.op)
                            OP_CLEAR:
                            begin
                                for (int i = 0; i < MAP_DEPTH; i++)
                                begin
                                    if ((i / WORDS_PER_CHIP) == int'(req.chip))
                                    begin
                                        row_valid_next[i] = 1'b0;
                                    end
                                end
                                // Block 0 holds the OTP area and is marked bad again by every clear.
                                ram_we    = 1'b1;
                                ram_waddr = {req.chip, {WPC_W{1'b0}}};
                                ram_wdata = WORD_W'(1);
                                row_valid_next[ram_waddr] = 1'b1;
                                fin = 1'b1;
                            end
                            OP_MARK:
                            begin
                                if (req.bad_in)
                                begin
                                    state_next = S_ACCESS;
                                end
                                else
                                begin
                                    fin = 1'b1;
                                end
                            end
                            OP_TEST:
                            begin
                                state_next = S_ACCESS;
                            end
                            OP_FIND:
                            begin
                                if (req.block == BLOCK_W'(BLOCK_COUNT - 1))
                                begin
                                    fin = 1'b1;
                                end
                                else
                                begin
                                    word_next  = start[BLOCK_W-1:BIT_W];
                                    mask_next  = {WORD_W{1'b1}} << start[BIT_W-1:0];
                                    ram_raddr  = {req.chip, start[BLOCK_W-1:BIT_W]};
                                    state_next = S_SCAN;
                                end
                            end
                            default:
                            begin
                                fin = 1'b1;
                            end
                        endcase
                    end
                end
            end
            S_ACCESS:
            begin
                if (op_reg == OP_MARK)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = {chip_reg, word_reg};
                    ram_wdata = word_data | (WORD_W'(1) << bit_reg);
                    row_valid_next[ram_waddr] = 1'b1;
                end
                else
                begin
                    res.is_bad = word_data[bit_reg];
                end
                fin = 1'b1;
            end
            S_SCAN:
            begin
                // The next word is read ahead while this one is checked.
                ram_raddr = {chip_reg, word_reg + WPC_W'(1)};
                if (good != '0)
                begin
                    res.found     = 1'b1;
                    res.next_good = {word_reg, lowest_one(good)};
                    fin = 1'b1;
                end
                else if (word_reg == WPC_W'(WORDS_PER_CHIP - 1))
                begin
                    fin = 1'b1;
                end
                else
                begin
                    word_next = word_reg + WPC_W'(1);
                    mask_next = {WORD_W{1'b1}};
                end
            end
            S_HOLD:
            begin
                if (can_emit)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (fin)
        begin
            if (can_emit)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            else
            begin
                pend_next  = res;
                state_next = S_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            row_valid_reg <= row_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chip_reg     <= chip_next;
        word_reg     <= word_next;
        bit_reg      <= bit_next;
        op_reg       <= op_next;
        mask_reg     <= mask_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        rd_valid_reg <= row_valid_reg[ram_raddr];
    end

endmodule

`default_nettype wire
